### rtl/bsp_pkg.sv
// bsp_pkg: shared types, constants and helpers of the beat score predictor
// used by bsp_front, bsp_back and beat_score_predictor_unit; no dependencies
package bsp_pkg;

  localparam int SCORE_DEPTH      = 512;
  localparam int MAX_PERIOD       = 128;
  localparam int TRANSITION_DEPTH = 256;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 1'd1;

  localparam logic [7:0]  BEAT_PERIOD_RST = 8'd43;
  localparam logic [15:0] ALPHA_RST       = 16'd58982;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_WTRANS = 2'd1;
  localparam logic [1:0] KIND_WEXP   = 2'd2;

  localparam int CNT_W = 10;
  localparam logic signed [CNT_W-1:0] CNT_MIN  = -10'sd512;
  localparam logic signed [CNT_W-1:0] CNT_MAX  = 10'sd511;
  localparam logic signed [CNT_W-1:0] PCD_RST  = 10'sd10;
  localparam logic signed [CNT_W-1:0] BCD_RST  = -10'sd1;

  localparam int MAG_W = 25;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [23:0] sample;
    logic [7:0]         weight_index;
    logic [15:0]        weight_value;
  } in_item_t;

  typedef struct packed {
    logic        beat_due;
    logic [31:0] latest_score;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_WTRANS,
    OP_WEXP,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [MAG_W-1:0] mag;
    logic [7:0]       idx;
    logic [15:0]      wval;
  } task_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MIX_MUL,
    ST_MIX_ADD,
    ST_EXP_MUL,
    ST_EXP_CMP,
    ST_RESULT
  } state_t;

  function automatic logic signed [CNT_W-1:0] cnt_dec(input logic signed [CNT_W-1:0] x);
    cnt_dec = (x == CNT_MIN) ? x : x - 10'sd1;
  endfunction

  function automatic logic signed [CNT_W-1:0] cnt_clamp(input logic signed [CNT_W:0] x);
    if (x > 11'sd511) cnt_clamp = CNT_MAX;
    else if (x < -11'sd512) cnt_clamp = CNT_MIN;
    else cnt_clamp = x[CNT_W-1:0];
  endfunction

endpackage

### rtl/bsp_front.sv
// bsp_front: accepts input transactions, classifies them and queues them
// depends on bsp_pkg
module bsp_front #(
  parameter int MAX_PERIOD       = bsp_pkg::MAX_PERIOD,
  parameter int TRANSITION_DEPTH = bsp_pkg::TRANSITION_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  bsp_pkg::in_item_t in_data,
  output logic             in_stall,
  output logic             task_valid,
  output bsp_pkg::task_t   task_data,
  input  logic             task_pop
);

  bsp_pkg::task_t q_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  bsp_pkg::task_t cls;
  logic           push;
  logic [23:0]    raw;

  always_comb begin
    raw = in_data.sample;
    cls.idx  = in_data.weight_index;
    cls.wval = in_data.weight_value;
    // magnitude of the sample plus one lsb
    cls.mag  = (raw[23] ? (25'h1000000 - 25'(raw)) : 25'(raw)) + 25'd1;
    case (in_data.kind)
      bsp_pkg::KIND_SAMPLE: cls.op = bsp_pkg::OP_SAMPLE;
      bsp_pkg::KIND_WTRANS:
        cls.op = (16'(in_data.weight_index) < 16'(TRANSITION_DEPTH)) ?
                 bsp_pkg::OP_WTRANS : bsp_pkg::OP_NOP;
      bsp_pkg::KIND_WEXP:
        cls.op = (16'(in_data.weight_index) < 16'(MAX_PERIOD)) ?
                 bsp_pkg::OP_WEXP : bsp_pkg::OP_NOP;
      default: cls.op = bsp_pkg::OP_NOP;
    endcase
  end

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign task_valid = (cnt_r != 2'd0);
  assign task_data  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (task_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(task_pop);
    end
  end

endmodule

### rtl/bsp_back.sv
// bsp_back: score history, weight tables, window max scan, mix and beat prediction
// depends on bsp_pkg
module bsp_back #(
  parameter int SCORE_DEPTH      = bsp_pkg::SCORE_DEPTH,
  parameter int MAX_PERIOD       = bsp_pkg::MAX_PERIOD,
  parameter int TRANSITION_DEPTH = bsp_pkg::TRANSITION_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         beat_period,
  input  logic [15:0]        alpha,
  input  logic               task_valid,
  input  bsp_pkg::task_t     task_data,
  output logic               task_pop,
  output logic               res_valid,
  output bsp_pkg::out_item_t res_data,
  input  logic               res_take
);

  localparam int HAW  = $clog2(SCORE_DEPTH);
  localparam int TAW  = $clog2(TRANSITION_DEPTH);
  localparam int EAW  = $clog2(MAX_PERIOD);
  localparam int PERW = $clog2(MAX_PERIOD + 1);
  localparam int NW   = $clog2(2 * MAX_PERIOD + 2);
  localparam int FW   = $clog2(SCORE_DEPTH + 1);
  localparam int PW   = $clog2(SCORE_DEPTH + 2 * MAX_PERIOD + 1) + 1;

  logic [31:0] hist_mem  [SCORE_DEPTH];
  logic [31:0] fut_mem   [MAX_PERIOD];
  logic [15:0] trans_mem [TRANSITION_DEPTH];
  logic [15:0] exp_mem   [MAX_PERIOD];
  logic [31:0] hist_rd, fut_rd;
  logic [15:0] trans_rd, exp_rd;

  bsp_pkg::state_t state_r, state_nxt;

  logic [HAW-1:0]  wp_r;
  logic [FW-1:0]   fill_r;
  logic [NW-1:0]   n_r;
  logic [PERW-1:0] k_r;
  logic            pred_r;
  logic [bsp_pkg::MAG_W-1:0] mag_r;
  logic [31:0]     best_r, pbest_r, latest_r;
  logic [41:0]     prod_a_r;
  logic [47:0]     prod_b_r;
  logic signed [bsp_pkg::CNT_W-1:0] pcd_r, bcd_r;
  logic            due_r;
  logic            s1_v_r, s1_zero_r, s1_fut_r, s2_v_r;
  logic [31:0]     s2_val_r;

  // derived period values
  logic [15:0]     bp_w, half_w, len_w;
  logic [PERW-1:0] per, half;
  logic [NW-1:0]   win_len;
  always_comb begin
    bp_w = 16'(beat_period);
    if (bp_w < 16'd2) bp_w = 16'd2;
    else if (bp_w > 16'(MAX_PERIOD)) bp_w = 16'(MAX_PERIOD);
    per    = bp_w[PERW-1:0];
    half_w = (bp_w + 16'd1) >> 1;
    half   = half_w[PERW-1:0];
    len_w  = (bp_w << 1) - half_w + 16'd1;
    win_len = len_w[NW-1:0];
  end

  // scan issue stage: position of this window element
  logic [PW-1:0]  u, base, pos_u, fut_off;
  logic [HAW:0]   hphys;
  logic [15:0]    n_w;
  logic           issue, zero, inhist, scan_done;
  always_comb begin
    u       = PW'(SCORE_DEPTH) + PW'(k_r) + PW'(n_r);
    base    = PW'(per) << 1;
    pos_u   = u - base;
    fut_off = pos_u - PW'(SCORE_DEPTH);
    inhist  = pos_u < PW'(SCORE_DEPTH);
    n_w     = 16'(n_r);
    hphys   = (HAW+1)'(wp_r) + pos_u[HAW:0];
    if (hphys >= (HAW+1)'(SCORE_DEPTH)) hphys = hphys - (HAW+1)'(SCORE_DEPTH);
    zero = (u < base)
        || (inhist && (pos_u < PW'(SCORE_DEPTH) - PW'(fill_r)))
        || (!inhist && (fut_off >= PW'(MAX_PERIOD)))
        || (n_w >= 16'(TRANSITION_DEPTH));
    issue     = (state_r == bsp_pkg::ST_SCAN) && (n_r != win_len);
    scan_done = (n_r == win_len) && !s1_v_r && !s2_v_r;
  end

  // mix and prediction helpers
  logic [48:0] mix_sum;
  logic [31:0] ns, ev;
  logic [16:0] inv_a;
  logic signed [bsp_pkg::CNT_W-1:0] pcd_dec, bcd_dec, bcd_new;
  logic        last_k;
  always_comb begin
    inv_a   = 17'h10000 - 17'(alpha);
    mix_sum = 49'(prod_a_r) + 49'(prod_b_r);
    ns      = mix_sum[48] ? 32'hFFFF_FFFF : mix_sum[47:16];
    ev      = prod_b_r[47:16];
    pcd_dec = bsp_pkg::cnt_dec(pcd_r);
    bcd_dec = bsp_pkg::cnt_dec(bcd_r);
    bcd_new = (ev > pbest_r) ? bsp_pkg::CNT_W'(k_r) : bcd_r;
    last_k  = (16'(k_r) + 16'd1) >= 16'(per);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsp_pkg::ST_IDLE:
        if (task_valid)
          state_nxt = (task_data.op == bsp_pkg::OP_SAMPLE) ? bsp_pkg::ST_SCAN
                                                           : bsp_pkg::ST_RESULT;
      bsp_pkg::ST_SCAN:
        if (scan_done) state_nxt = pred_r ? bsp_pkg::ST_EXP_MUL : bsp_pkg::ST_MIX_MUL;
      bsp_pkg::ST_MIX_MUL: state_nxt = bsp_pkg::ST_MIX_ADD;
      bsp_pkg::ST_MIX_ADD:
        state_nxt = (pcd_dec == '0) ? bsp_pkg::ST_SCAN : bsp_pkg::ST_RESULT;
      bsp_pkg::ST_EXP_MUL: state_nxt = bsp_pkg::ST_EXP_CMP;
      bsp_pkg::ST_EXP_CMP:
        state_nxt = last_k ? bsp_pkg::ST_RESULT : bsp_pkg::ST_SCAN;
      bsp_pkg::ST_RESULT:
        if (res_take) state_nxt = bsp_pkg::ST_IDLE;
      default: state_nxt = bsp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  logic hist_we, fut_we, trans_we, exp_we;
  always_comb begin
    task_pop  = (state_r == bsp_pkg::ST_IDLE) && task_valid;
    res_valid = (state_r == bsp_pkg::ST_RESULT);
    hist_we   = (state_r == bsp_pkg::ST_MIX_ADD);
    fut_we    = (state_r == bsp_pkg::ST_EXP_MUL);
    trans_we  = task_pop && (task_data.op == bsp_pkg::OP_WTRANS);
    exp_we    = task_pop && (task_data.op == bsp_pkg::OP_WEXP);
    res_data.beat_due     = due_r;
    res_data.latest_score = latest_r;
  end

  // memories
  logic [15:0] widx;
  assign widx = 16'(task_data.idx);
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[wp_r] <= ns;
    if (fut_we) fut_mem[k_r[EAW-1:0]] <= best_r;
    if (trans_we) trans_mem[widx[TAW-1:0]] <= task_data.wval;
    if (exp_we) exp_mem[widx[EAW-1:0]] <= task_data.wval;
    hist_rd  <= hist_mem[hphys[HAW-1:0]];
    fut_rd   <= fut_mem[fut_off[EAW-1:0]];
    trans_rd <= trans_mem[n_w[TAW-1:0]];
    exp_rd   <= exp_mem[k_r[EAW-1:0]];
  end

  // scan pipeline payload
  logic [47:0] s1_prod;
  assign s1_prod = 48'(s1_fut_r ? fut_rd : hist_rd) * 48'(trans_rd);
  always_ff @(posedge clk) begin
    s1_zero_r <= zero;
    s1_fut_r  <= !inhist;
    s2_val_r  <= s1_zero_r ? 32'd0 : s1_prod[47:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bsp_pkg::ST_IDLE;
      wp_r     <= '0;
      fill_r   <= '0;
      n_r      <= '0;
      k_r      <= '0;
      pred_r   <= 1'b0;
      best_r   <= '0;
      pbest_r  <= '0;
      latest_r <= '0;
      pcd_r    <= bsp_pkg::PCD_RST;
      bcd_r    <= bsp_pkg::BCD_RST;
      due_r    <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      if (issue) n_r <= n_r + NW'(1);
      if (s2_v_r && (s2_val_r > best_r)) best_r <= s2_val_r;
      case (state_r)
        bsp_pkg::ST_IDLE: begin
          if (task_valid) begin
            mag_r  <= task_data.mag;
            n_r    <= '0;
            k_r    <= '0;
            best_r <= '0;
            pred_r <= 1'b0;
            due_r  <= 1'b0;
          end
        end
        bsp_pkg::ST_MIX_MUL: begin
          prod_a_r <= 42'(inv_a) * 42'(mag_r);
          prod_b_r <= 48'(alpha) * 48'(best_r);
        end
        bsp_pkg::ST_MIX_ADD: begin
          wp_r     <= (wp_r == HAW'(SCORE_DEPTH - 1)) ? '0 : wp_r + HAW'(1);
          if (fill_r != FW'(SCORE_DEPTH)) fill_r <= fill_r + FW'(1);
          latest_r <= ns;
          pcd_r    <= pcd_dec;
          bcd_r    <= bcd_dec;
          due_r    <= (bcd_dec == '0);
          // prediction starts over a fresh set of future scores
          pred_r   <= 1'b1;
          k_r      <= '0;
          n_r      <= '0;
          best_r   <= '0;
          pbest_r  <= '0;
        end
        bsp_pkg::ST_EXP_MUL: prod_b_r <= 48'(best_r) * 48'(exp_rd);
        bsp_pkg::ST_EXP_CMP: begin
          if (ev > pbest_r) pbest_r <= ev;
          bcd_r <= bcd_new;
          if (last_k) begin
            pcd_r <= bsp_pkg::cnt_clamp((bsp_pkg::CNT_W+1)'(bcd_new) +
                                        (bsp_pkg::CNT_W+1)'(half));
            due_r <= (bcd_new == '0);
          end else begin
            k_r    <= k_r + PERW'(1);
            n_r    <= '0;
            best_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/beat_score_predictor_unit.sv
// beat_score_predictor_unit: top level of the cumulative score beat tracker
// depends on bsp_pkg, bsp_front and bsp_back
//
// usage: every input transaction (kind 0 onset sample, kind 1 transition
// weight write, kind 2 expectation weight write) gives exactly one output
// transaction with the beat flag and the newest cumulative score.
// channels use valid/stall; configuration (beat period, alpha) is a plain
// write port; the user must write it only while the block is idle, and the
// block does not enforce this. a two-entry queue between the front and the
// back lets input transactions be taken while the back is busy; one output
// register holds the result. the time a sample takes is set by the window
// scan that reads one history entry a cycle; a sample that triggers a
// prediction adds P more scans through the same unit. reset: synchronous,
// clears the score history (by fill count), the queue and the output
// register, and sets the countdowns to their start values; weight tables
// are undefined until written. a stalled output holds its transaction and
// the back waits.
module beat_score_predictor_unit #(
  parameter int SCORE_DEPTH      = bsp_pkg::SCORE_DEPTH,
  parameter int MAX_PERIOD       = bsp_pkg::MAX_PERIOD,
  parameter int TRANSITION_DEPTH = bsp_pkg::TRANSITION_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  bsp_pkg::in_item_t               in_data,
  output logic                            in_stall,
  output logic                            out_valid,
  output bsp_pkg::out_item_t              out_data,
  input  logic                            out_stall,
  input  logic                            cfg_we,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsp_pkg::CFG_W-1:0]       cfg_wdata
);

  logic [7:0]  beat_period_r;
  logic [15:0] alpha_r;
  logic               task_valid, task_pop, res_valid, res_take;
  bsp_pkg::task_t     task_data;
  bsp_pkg::out_item_t res_data, out_r;
  logic               out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_period_r <= bsp_pkg::BEAT_PERIOD_RST;
      alpha_r       <= bsp_pkg::ALPHA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bsp_pkg::CFG_BEAT_PERIOD: beat_period_r <= cfg_wdata[7:0];
        bsp_pkg::CFG_ALPHA:       alpha_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bsp_front #(
    .MAX_PERIOD(MAX_PERIOD),
    .TRANSITION_DEPTH(TRANSITION_DEPTH)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .task_valid(task_valid), .task_data(task_data), .task_pop(task_pop)
  );

  bsp_back #(
    .SCORE_DEPTH(SCORE_DEPTH),
    .MAX_PERIOD(MAX_PERIOD),
    .TRANSITION_DEPTH(TRANSITION_DEPTH)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .beat_period(beat_period_r), .alpha(alpha_r),
    .task_valid(task_valid), .task_data(task_data), .task_pop(task_pop),
    .res_valid(res_valid), .res_data(res_data), .res_take(res_take)
  );

  // output register takes a result when empty or being drained
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (res_take) out_r <= res_data;
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_take) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_out_after_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !res_take)
    else $error("stalled output transaction overwritten");
  a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |-> res_valid)
    else $error("result taken without a valid result");
  a_take_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_valid)
    else $error("taken result not presented");

endmodule

### sim/testbench.sv
// testbench: self-checking bench for beat_score_predictor_unit
// depends on bsp_pkg and the beat_score_predictor_unit rtl; a built-in tracker model
// predicts every output transaction and compares it field by field
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // periods stay at or below 16, so only these weight entries are ever read
  localparam int TW_N = 25;
  localparam int EW_N = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  bsp_pkg::in_item_t in_data = '0;
  logic in_stall;
  logic out_valid;
  bsp_pkg::out_item_t out_data;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [bsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bsp_pkg::CFG_W-1:0] cfg_wdata = '0;

  beat_score_predictor_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // tracker state mirrored in the bench
  logic [31:0] hist [bsp_pkg::SCORE_DEPTH];
  logic [31:0] future [bsp_pkg::MAX_PERIOD];
  logic [15:0] trans_w [bsp_pkg::TRANSITION_DEPTH];
  logic [15:0] expect_w [bsp_pkg::MAX_PERIOD];
  int pred_cd;
  int beat_cd;
  logic [7:0] period_reg;
  logic [15:0] alpha_reg;

  bsp_pkg::in_item_t pending_items[$];
  bsp_pkg::out_item_t score_queue[$];
  int idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both
  bit hold_sender = 1'b0;
  bit in_acc = 1'b0;
  int mismatches = 0;
  int checked = 0;
  int samples_seen = 0;
  int beats_seen = 0;

  function automatic int clamp_cd(int v);
    if (v < -512) return -512;
    if (v > 511) return 511;
    return v;
  endfunction

  function automatic logic [31:0] score_at(int pos);
    if (pos < 0) return 32'd0;
    if (pos < bsp_pkg::SCORE_DEPTH) return hist[pos];
    pos -= bsp_pkg::SCORE_DEPTH;
    if (pos < bsp_pkg::MAX_PERIOD) return future[pos];
    return 32'd0;
  endfunction

  function automatic logic [31:0] window_max(int first, int last);
    logic [31:0] best;
    logic [63:0] v;
    logic [15:0] w;
    int n;
    best = 0;
    n = 0;
    for (int i = first; i <= last; i++) begin
      w = (n < bsp_pkg::TRANSITION_DEPTH) ? trans_w[n] : 16'd0;
      v = (64'(score_at(i)) * w) >> 16;
      if (v[31:0] > best) best = v[31:0];
      n++;
    end
    return best;
  endfunction

  function automatic logic [31:0] blend(logic [31:0] s, logic [31:0] m, logic [16:0] a);
    logic [63:0] r;
    r = ((64'd65536 - a) * s + 64'(a) * m) >> 16;
    return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  function automatic void forecast_beat(int p);
    int half;
    logic [31:0] best;
    logic [63:0] v;
    half = (p + 1) / 2;
    best = 0;
    for (int k = 0; k < p; k++)
      future[k] = blend(32'd0, window_max(bsp_pkg::SCORE_DEPTH - 2 * p + k,
                                          bsp_pkg::SCORE_DEPTH - half + k), 17'd65536);
    for (int k = 0; k < p; k++) begin
      v = (64'(future[k]) * expect_w[k]) >> 16;
      if (v[31:0] > best) begin
        best = v[31:0];
        beat_cd = k;
      end
    end
    pred_cd = clamp_cd(beat_cd + half);
  endfunction

  function automatic bsp_pkg::out_item_t track_item(bsp_pkg::in_item_t it);
    bsp_pkg::out_item_t r;
    int p;
    logic [24:0] mag;
    logic [31:0] m;
    r.beat_due = 1'b0;
    if (it.kind == bsp_pkg::KIND_SAMPLE) begin
      p = (period_reg < 2) ? 2 :
          (period_reg > bsp_pkg::MAX_PERIOD) ? bsp_pkg::MAX_PERIOD : period_reg;
      mag = it.sample[23] ? (25'h100_0000 - it.sample[23:0]) : {1'b0, it.sample[23:0]};
      m = window_max(bsp_pkg::SCORE_DEPTH - 2 * p, bsp_pkg::SCORE_DEPTH - (p + 1) / 2);
      pred_cd = clamp_cd(pred_cd - 1);
      beat_cd = clamp_cd(beat_cd - 1);
      for (int i = 0; i < bsp_pkg::SCORE_DEPTH - 1; i++) hist[i] = hist[i + 1];
      hist[bsp_pkg::SCORE_DEPTH - 1] = blend(32'(mag) + 32'd1, m, {1'b0, alpha_reg});
      if (pred_cd == 0) forecast_beat(p);
      if (beat_cd == 0) r.beat_due = 1'b1;
    end else if (it.kind == bsp_pkg::KIND_WTRANS) begin
      trans_w[it.weight_index] = it.weight_value;
    end else if (it.kind == bsp_pkg::KIND_WEXP) begin
      if (it.weight_index < bsp_pkg::MAX_PERIOD)
        expect_w[it.weight_index[6:0]] = it.weight_value;
    end
    r.latest_score = hist[bsp_pkg::SCORE_DEPTH - 1];
    return r;
  endfunction

  // input acceptance, prediction and output checking
  always @(posedge clk) begin
    bsp_pkg::out_item_t want;
    in_acc <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (in_data.kind == bsp_pkg::KIND_SAMPLE) samples_seen++;
        score_queue.push_back(track_item(in_data));
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (out_data.beat_due) beats_seen++;
        if (score_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output transaction %p", out_data);
        end else begin
          want = score_queue.pop_front();
          if (want.beat_due !== out_data.beat_due ||
              want.latest_score !== out_data.latest_score) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected beat %0d score %h, got beat %0d score %h",
                       want.beat_due, want.latest_score, out_data.beat_due,
                       out_data.latest_score);
          end
        end
      end
    end
  end

  // driver and receiver stall at the falling edge
  always @(negedge clk) begin
    bit gap;
    gap = (idle_mode == 1 || idle_mode == 3) &&
          ($urandom_range(99) < ((idle_mode == 1) ? 48 : 35));
    if (!(in_valid && !in_acc)) begin
      if (rst_n && !hold_sender && !gap && pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= (idle_mode == 2 || idle_mode == 3) &&
                 ($urandom_range(99) < ((idle_mode == 2) ? 48 : 35));
  end

  function automatic bsp_pkg::in_item_t rand_item();
    bsp_pkg::in_item_t it;
    int r;
    it.kind = bsp_pkg::KIND_SAMPLE;
    it.sample = $urandom;
    it.weight_index = $urandom;
    it.weight_value = $urandom;
    r = $urandom_range(99);
    if (r >= 90) it.kind = KIND_UNUSED;
    else if (r >= 82) it.kind = bsp_pkg::KIND_WTRANS;
    else if (r >= 75) it.kind = bsp_pkg::KIND_WEXP;
    else if (r >= 70) it.sample = (r & 1) ? 24'sh7FFFFF : -24'sh800000;
    else if (r >= 60) it.sample = $urandom_range(3) - 2;
    return it;
  endfunction

  function automatic bsp_pkg::in_item_t make_item(logic [1:0] k, logic [23:0] s,
                                                  logic [7:0] idx, logic [15:0] w);
    bsp_pkg::in_item_t it;
    it.kind = k;
    it.sample = s;
    it.weight_index = idx;
    it.weight_value = w;
    return it;
  endfunction

  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() > 0 || in_valid || score_queue.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [bsp_pkg::CFG_IDX_W-1:0] idx,
                           logic [bsp_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bsp_pkg::CFG_BEAT_PERIOD) period_reg = val[7:0];
    else alpha_reg = val;
  endtask

  task automatic run_phase(logic [7:0] p, logic [15:0] a, int mode, int n);
    write_cfg(bsp_pkg::CFG_BEAT_PERIOD, {8'd0, p});
    write_cfg(bsp_pkg::CFG_ALPHA, a);
    idle_mode = mode;
    for (int i = 0; i < n; i++) pending_items.push_back(rand_item());
    drain();
  endtask

  initial begin
    for (int i = 0; i < bsp_pkg::SCORE_DEPTH; i++) hist[i] = 0;
    for (int i = 0; i < bsp_pkg::MAX_PERIOD; i++) future[i] = 0;
    pred_cd = bsp_pkg::PCD_RST;
    beat_cd = bsp_pkg::BCD_RST;
    period_reg = bsp_pkg::BEAT_PERIOD_RST;
    alpha_reg = bsp_pkg::ALPHA_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // keep the window inside the weight entries written below
    write_cfg(bsp_pkg::CFG_BEAT_PERIOD, 16'd16);

    // fill the weight entries in use so no unwritten weight is ever read
    pending_items.push_back(make_item(bsp_pkg::KIND_WTRANS, 24'd0, 8'd0, 16'hFFFF));
    pending_items.push_back(make_item(bsp_pkg::KIND_WTRANS, 24'd0, 8'd1, 16'h0000));
    for (int i = 2; i < TW_N; i++)
      pending_items.push_back(make_item(bsp_pkg::KIND_WTRANS, 24'(i), 8'(i),
                                        16'($urandom)));
    pending_items.push_back(make_item(bsp_pkg::KIND_WEXP, 24'd0, 8'd0, 16'h0000));
    pending_items.push_back(make_item(bsp_pkg::KIND_WEXP, 24'd0, 8'd1, 16'hFFFF));
    for (int i = 2; i < EW_N; i++)
      pending_items.push_back(make_item(bsp_pkg::KIND_WEXP, 24'd0, 8'(i), 16'($urandom)));
    // directed: sample extremes, ignored writes and the unused kind
    pending_items.push_back(make_item(bsp_pkg::KIND_SAMPLE, 24'h800000, 8'hFF, 16'hFFFF));
    pending_items.push_back(make_item(bsp_pkg::KIND_SAMPLE, 24'h7FFFFF, 8'h00, 16'h0000));
    pending_items.push_back(make_item(bsp_pkg::KIND_SAMPLE, 24'h000000, 8'h00, 16'h0000));
    pending_items.push_back(make_item(bsp_pkg::KIND_SAMPLE, 24'hFFFFFF, 8'h00, 16'h0000));
    pending_items.push_back(make_item(bsp_pkg::KIND_SAMPLE, 24'h000001, 8'h00, 16'h0000));
    pending_items.push_back(make_item(bsp_pkg::KIND_WEXP, 24'hFFFFFF, 8'd128, 16'h1234));
    pending_items.push_back(make_item(bsp_pkg::KIND_WEXP, 24'd0, 8'd255, 16'hFFFF));
    pending_items.push_back(make_item(bsp_pkg::KIND_WTRANS, 24'd0, 8'd255, 16'h8000));
    pending_items.push_back(make_item(KIND_UNUSED, 24'h5A5A5A, 8'hA5, 16'hA5A5));
    for (int i = 0; i < 6; i++)
      pending_items.push_back(make_item(bsp_pkg::KIND_SAMPLE, 24'($urandom), 8'd0, 16'd0));
    drain();

    run_phase(8'd0, 16'd0, 1, 10);         // period clamps up to 2
    run_phase(8'd16, 16'd65535, 3, 8);
    run_phase(8'd2, 16'd65535, 2, 8);
    run_phase(8'd11, 16'd12345, 3, 8);

    // sender holds off until everything outstanding has come back
    write_cfg(bsp_pkg::CFG_BEAT_PERIOD, 16'd8);
    write_cfg(bsp_pkg::CFG_ALPHA, 16'($urandom));
    idle_mode = 0;
    for (int i = 0; i < 5; i++) pending_items.push_back(rand_item());
    do @(posedge clk);
    while (pending_items.size() > 0 || in_valid);
    hold_sender = 1'b1;
    for (int i = 0; i < 5; i++) pending_items.push_back(rand_item());
    do @(posedge clk);
    while (score_queue.size() > 0);
    hold_sender = 1'b0;
    drain();

    $display("covered %0d onset samples and %0d checked output transactions, %0d beats",
             samples_seen, checked, beats_seen);
    $display("periods 0 (clamped to 2) up to 16, alpha 0 and 65535, four idle patterns");
    if (mismatches == 0 && score_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d transactions left over", mismatches, score_queue.size());
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

endmodule
